[rtl/core/ssis_pkg.sv]
// ----------------------------------------------------------------------------
// ssis_pkg
// shared sizes, types and state codes of the sparse segment index sorter
// ----------------------------------------------------------------------------
package ssis_pkg;

  localparam int MAX_SEG_LEN = 64;
  localparam int DEPTH       = 64;
  localparam int CAP         = (MAX_SEG_LEN > DEPTH) ? DEPTH :
                               ((MAX_SEG_LEN < 1) ? 1 : MAX_SEG_LEN);
  localparam int AW          = $clog2(DEPTH);
  localparam int CW          = $clog2(DEPTH + 1);
  localparam int KEY_W       = 31;
  localparam int VAL_W       = 64;
  localparam int ENT_W       = KEY_W + VAL_W;
  localparam int TDATA_W     = ((ENT_W + 7) / 8) * 8;

  localparam logic [CW-1:0] CAP_C = CW'(CAP);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic place;
    logic drop;
    logic drain;
  } ssis_cmd_t;

  typedef struct packed {
    logic full;
    logic pos_zero;
    logic key_gt;
    logic hold_end;
    logic drain_done;
  } ssis_sts_t;

endpackage

[rtl/core/ssis_ctrl.sv]
// ----------------------------------------------------------------------------
// ssis_ctrl
// state machine: takes a request, steps the insertion, runs the drain
// ----------------------------------------------------------------------------
module ssis_ctrl import ssis_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ssis_sts_t sts,
  output ssis_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  state_t fin_state;

  assign in_tready = (state_r == S_IDLE);
  assign fin_state = sts.hold_end ? S_DRAIN : S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.full) begin
          cmd.drop  = 1'b1;
          state_nxt = fin_state;
        end else if (sts.pos_zero || !sts.key_gt) begin
          cmd.place = 1'b1;
          state_nxt = fin_state;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
        if (sts.drain_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) && !sts.hold_end && (cmd.place || cmd.drop) |=> in_tready)
    else $error("insertion finished without returning to idle");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) && sts.hold_end && (cmd.place || cmd.drop) |=> cmd.drain)
    else $error("segment end did not start the drain");

  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.shift, cmd.place, cmd.drop}))
    else $error("conflicting insertion commands");

endmodule

[rtl/core/ssis_dpath.sv]
// ----------------------------------------------------------------------------
// ssis_dpath
// entry buffer, insertion shifter and drain pipeline with output register
// ----------------------------------------------------------------------------
module ssis_dpath import ssis_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ssis_cmd_t          cmd,
  output ssis_sts_t          sts,
  input  logic [TDATA_W-1:0] in_tdata,
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);

  logic [ENT_W-1:0] mem [DEPTH];

  logic [KEY_W-1:0] hold_key_r;
  logic [VAL_W-1:0] hold_val_r;
  logic             hold_end_r;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic             drop_r, drop_nxt;
  logic [CW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic             rv_r, rv_nxt;
  logic             rd_last_r;
  logic [ENT_W-1:0] rdata_r;
  logic             out_valid_r, out_valid_nxt;
  logic [ENT_W-1:0] out_ent_r;
  logic             out_last_r;
  logic             out_ovf_r;

  logic [CW-1:0]    ra_full;
  logic [AW-1:0]    ra;
  logic             re;
  logic             we;
  logic [ENT_W-1:0] wd;
  logic             load_out;
  logic             issue;
  logic             done;

  assign load_out = cmd.drain && rv_r && (!out_valid_r || out_tready);
  assign issue    = cmd.drain && (rd_ptr_r < fill_r) && (!rv_r || load_out);
  assign done     = load_out && rd_last_r;

  assign ra_full = cmd.drain ? rd_ptr_r :
                   (cmd.shift ? (pos_r - CW'(2)) : (fill_r - CW'(1)));
  assign ra      = ra_full[AW-1:0];
  assign re      = cmd.load || cmd.shift || issue;
  assign we      = cmd.shift || cmd.place;
  assign wd      = cmd.shift ? rdata_r : {hold_val_r, hold_key_r};

  assign sts.full       = (fill_r == CAP_C);
  assign sts.pos_zero   = (pos_r == '0);
  assign sts.key_gt     = (rdata_r[KEY_W-1:0] > hold_key_r);
  assign sts.hold_end   = hold_end_r;
  assign sts.drain_done = done;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos_r[AW-1:0]] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    rd_ptr_nxt    = rd_ptr_r;
    rv_nxt        = rv_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      pos_nxt    = fill_r;
      rd_ptr_nxt = '0;
      rv_nxt     = 1'b0;
    end
    if (cmd.shift) begin
      pos_nxt = pos_r - CW'(1);
    end
    if (cmd.place) begin
      fill_nxt = fill_r + CW'(1);
    end
    if (cmd.drop) begin
      drop_nxt = 1'b1;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      rv_nxt        = 1'b0;
    end
    if (issue) begin
      rd_ptr_nxt = rd_ptr_r + CW'(1);
      rv_nxt     = 1'b1;
    end
    if (done) begin
      fill_nxt = '0;
      drop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      fill_r      <= '0;
      drop_r      <= 1'b0;
      rd_ptr_r    <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hold_key_r <= in_tdata[KEY_W-1:0];
      hold_val_r <= in_tdata[ENT_W-1:KEY_W];
      hold_end_r <= in_tlast;
    end
    if (issue) begin
      rd_last_r <= (rd_ptr_r == (fill_r - CW'(1)));
    end
    if (load_out) begin
      out_ent_r  <= rdata_r;
      out_last_r <= rd_last_r;
      out_ovf_r  <= drop_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W - ENT_W){1'b0}}, out_ent_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= CAP_C)
    else $error("fill count beyond capacity");

  assert property (@(posedge clk) disable iff (!rst_n) cmd.place |-> fill_r < CAP_C)
    else $error("entry stored into a full buffer");

  assert property (@(posedge clk) disable iff (!rst_n) cmd.shift |-> pos_r != '0)
    else $error("shift below the first entry");

  assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (fill_r == '0) && !drop_r)
    else $error("segment state not cleared after drain");

endmodule

[rtl/core/sparse_segment_index_sort_unit.sv]
// insertion: each stored key greater than the new entry's key is shifted up one place,
//   one buffer entry per cycle, until a key that is not greater or the first entry is reached
// once the segment's last entry is placed or dropped, the drain reads into rdata_r and
//   out_ent_r, one result per cycle while out_tready is high (one read port of the buffer)
// reset is synchronous and active low: clears fill count, overflow flag and handshakes;
//   buffer contents are not cleared and no clearing pass runs
// ----------------------------------------------------------------------------
// sparse_segment_index_sort_unit
// buffers one sparse row or column and emits it sorted by index, stable
// ----------------------------------------------------------------------------
module sparse_segment_index_sort_unit import ssis_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // entry_index, entry_value
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // sorted_index, sorted_value
  output logic               out_tlast,
  output logic               out_tuser   // overflow
);

  ssis_cmd_t cmd;
  ssis_sts_t sts;

  ssis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssis_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
